[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising clock edge, skipped while reset is asserted.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check prop on every rising clock edge, reset included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/afc_pkg.sv]
// ----------------------------------------------------------------------------
// afc_pkg
// Shared constants and types for the box frustum culling block.
// ----------------------------------------------------------------------------
package afc_pkg;

  localparam int PLANE_COUNT_DEF = 6;
  localparam int COORD_BITS_DEF  = 16;
  localparam int REG_COUNT       = 6;
  localparam int FIELD_BITS      = 16;
  localparam int IN_FIELDS       = 9;
  localparam int AXES            = 3;
  localparam int BOUNDS          = 2 * AXES;
  localparam int COEF_BITS       = 16;
  localparam int PLANE_BITS      = 64;
  localparam int D_SHIFT         = 14;
  localparam int CFG_ADDR_BITS   = 6;
  localparam int CFG_IDX_LSB     = 3;
  localparam int CFG_IDX_BITS    = 3;

  typedef logic [PLANE_BITS-1:0] plane_t;

endpackage

[rtl/core/afc_cell.sv]
// ----------------------------------------------------------------------------
// afc_cell
// One plane of the culling chain: multiply the box bounds by the plane
// normal, then take the farthest corner and mark the box if it is behind.
// ----------------------------------------------------------------------------
module afc_cell #(
  parameter int COORD_BITS = afc_pkg::COORD_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  afc_pkg::plane_t                            plane,
  input  logic                                       up_valid,
  output logic                                       up_ready,
  input  logic                                       up_culled,
  input  logic [afc_pkg::BOUNDS*(COORD_BITS+1)-1:0]  up_bounds,
  output logic                                       dn_valid,
  input  logic                                       dn_ready,
  output logic                                       dn_culled,
  output logic [afc_pkg::BOUNDS*(COORD_BITS+1)-1:0]  dn_bounds
);

  localparam int CW = COORD_BITS + 1;
  localparam int PW = CW + afc_pkg::COEF_BITS;
  localparam int DW = afc_pkg::COEF_BITS + afc_pkg::D_SHIFT;
  localparam int SW = ((PW > DW) ? PW : DW) + 2;
  localparam int BW = afc_pkg::BOUNDS * CW;

  logic                 v1_r, v2_r;
  logic                 rdy1, rdy2;
  logic                 culled1_r, culled2_r;
  logic [BW-1:0]        bounds1_r, bounds2_r;
  logic signed [PW-1:0] prod_nxt [afc_pkg::BOUNDS];
  logic signed [PW-1:0] prod_r   [afc_pkg::BOUNDS];
  logic signed [PW-1:0] far      [afc_pkg::AXES];
  logic signed [afc_pkg::COEF_BITS-1:0] dcoef;
  logic signed [SW-1:0] sum;
  logic                 behind;

  assign rdy1     = !v1_r || rdy2;
  assign rdy2     = !v2_r || dn_ready;
  assign up_ready = rdy1;

  // Stage 1: both bounds of each axis times that axis' normal component.
  always_comb begin
    for (int k = 0; k < afc_pkg::BOUNDS; k++) begin
      prod_nxt[k] = PW'($signed(plane[(k >> 1)*afc_pkg::COEF_BITS +: afc_pkg::COEF_BITS]))
                  * PW'($signed(up_bounds[k*CW +: CW]));
    end
  end

  // Stage 2: the corner farthest along the normal decides the plane.
  always_comb begin
    for (int j = 0; j < afc_pkg::AXES; j++) begin
      far[j] = (prod_r[2*j] > prod_r[2*j+1]) ? prod_r[2*j] : prod_r[2*j+1];
    end
  end

  assign dcoef  = $signed(plane[3*afc_pkg::COEF_BITS +: afc_pkg::COEF_BITS]);
  assign sum    = SW'(far[0]) + SW'(far[1]) + SW'(far[2]) + (SW'(dcoef) <<< afc_pkg::D_SHIFT);
  assign behind = sum[SW-1] || (sum == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= up_valid;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      culled1_r <= up_culled;
      bounds1_r <= up_bounds;
      prod_r    <= prod_nxt;
    end
    if (rdy2 && v1_r) begin
      culled2_r <= culled1_r || behind;
      bounds2_r <= bounds1_r;
    end
  end

  assign dn_valid  = v2_r;
  assign dn_culled = culled2_r;
  assign dn_bounds = bounds2_r;

endmodule

[rtl/core/aabb_frustum_cull.sv]
// ----------------------------------------------------------------------------
// aabb_frustum_cull
// Frustum culling of offset axis-aligned boxes against configured planes.
// ----------------------------------------------------------------------------
// One box transfer is accepted per cycle while in_tready is high, and one
// visibility result leaves per box, in order, once the box has passed the
// front stage and every plane cell, where N is the number of planes tested
// (PLANE_COUNT, at most six). The front stage adds the offset to both bounds
// of each axis; then a chain of N plane cells follows, each with a multiply
// stage and a farthest-corner sum-and-compare stage. Stages that are empty let
// traffic close up, so input is taken while a result waits. Planes come from
// six 64-bit registers (a, b, c, d as signed 16-bit values from the low bits
// up) at byte offsets 0, 8, ... 40; after reset all planes are zero and every
// box reads as not visible. Write planes only while no box is in flight.
module aabb_frustum_cull #(
  parameter int PLANE_COUNT = afc_pkg::PLANE_COUNT_DEF,
  parameter int COORD_BITS  = afc_pkg::COORD_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_tvalid,
  output logic                                          in_tready,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
  // offset_x, offset_y, offset_z
  input  logic [afc_pkg::IN_FIELDS*afc_pkg::FIELD_BITS-1:0] in_tdata,
  output logic                                          out_tvalid,
  input  logic                                          out_tready,
  // visible, then zero fill
  output logic [7:0]                                    out_tdata,
  input  logic                                          cfg_psel,
  input  logic                                          cfg_penable,
  input  logic                                          cfg_pwrite,
  input  logic [afc_pkg::CFG_ADDR_BITS-1:0]             cfg_paddr,
  input  logic [afc_pkg::PLANE_BITS-1:0]                cfg_pwdata,
  output logic [afc_pkg::PLANE_BITS-1:0]                cfg_prdata,
  output logic                                          cfg_pready
);

`include "assert_macros.svh"

  localparam int NCELL = (PLANE_COUNT < afc_pkg::REG_COUNT) ? PLANE_COUNT : afc_pkg::REG_COUNT;
  localparam int CW    = COORD_BITS + 1;
  localparam int BW    = afc_pkg::BOUNDS * CW;
  localparam logic [afc_pkg::CFG_IDX_BITS-1:0] LAST_IDX =
    afc_pkg::CFG_IDX_BITS'(afc_pkg::REG_COUNT - 1);

  afc_pkg::plane_t                  plane_r [afc_pkg::REG_COUNT];
  logic [afc_pkg::CFG_IDX_BITS-1:0] cfg_idx;
  logic                             cfg_wr;

  logic          v0_r;
  logic [BW-1:0] bounds0_r;
  logic [BW-1:0] bounds_nxt;

  logic          ch_v      [NCELL+1];
  logic          ch_rdy    [NCELL+1];
  logic          ch_culled [NCELL+1];
  logic [BW-1:0] ch_bounds [NCELL+1];

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[afc_pkg::CFG_IDX_LSB +: afc_pkg::CFG_IDX_BITS];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < afc_pkg::REG_COUNT; i++) plane_r[i] <= '0;
    end else if (cfg_wr && cfg_idx <= LAST_IDX) begin
      plane_r[cfg_idx] <= cfg_pwdata;
    end
  end

  assign cfg_prdata = (cfg_idx <= LAST_IDX) ? plane_r[cfg_idx] : '0;

  // Front stage: offset both bounds of each axis.
  always_comb begin
    logic [31:0]                  fz;
    logic [31:0]                  oz;
    logic signed [COORD_BITS-1:0] bnd;
    logic signed [COORD_BITS-1:0] off;
    for (int k = 0; k < afc_pkg::BOUNDS; k++) begin
      fz  = 32'(in_tdata[((k & 1) * afc_pkg::AXES + (k >> 1)) * afc_pkg::FIELD_BITS
                         +: afc_pkg::FIELD_BITS]);
      oz  = 32'(in_tdata[(2 * afc_pkg::AXES + (k >> 1)) * afc_pkg::FIELD_BITS
                         +: afc_pkg::FIELD_BITS]);
      bnd = $signed(fz[COORD_BITS-1:0]);
      off = $signed(oz[COORD_BITS-1:0]);
      bounds_nxt[k*CW +: CW] = CW'(bnd) + CW'(off);
    end
  end

  assign in_tready = !v0_r || ch_rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (in_tready) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) bounds0_r <= bounds_nxt;
  end

  assign ch_v[0]      = v0_r;
  assign ch_culled[0] = 1'b0;
  assign ch_bounds[0] = bounds0_r;

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    afc_cell #(
      .COORD_BITS (COORD_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .plane     (plane_r[g]),
      .up_valid  (ch_v[g]),
      .up_ready  (ch_rdy[g]),
      .up_culled (ch_culled[g]),
      .up_bounds (ch_bounds[g]),
      .dn_valid  (ch_v[g+1]),
      .dn_ready  (ch_rdy[g+1]),
      .dn_culled (ch_culled[g+1]),
      .dn_bounds (ch_bounds[g+1])
    );
  end

  assign ch_rdy[NCELL] = out_tready;
  assign out_tvalid    = ch_v[NCELL];
  assign out_tdata     = {7'b0, !ch_culled[NCELL]};

  `ASSERT_CLK_RST(a_idle_takes_input, clk, rst_n, !out_tvalid |-> in_tready, "input stalled with empty output")
  `ASSERT_CLK_RST(a_zero_plane_culls, clk, rst_n, (out_tvalid && plane_r[0] == '0) |-> (out_tdata[0] == 1'b0), "zero plane passed a box")
  `ASSERT_CLK_RST(a_cfg_write_lands, clk, rst_n, (cfg_wr && cfg_idx == '0) |=> (plane_r[0] == $past(cfg_pwdata)), "plane write lost")
  `ASSERT_CLK_RST(a_cfg_bad_index, clk, rst_n, (cfg_wr && cfg_idx > LAST_IDX) |=> (plane_r[LAST_IDX] == $past(plane_r[LAST_IDX])), "write beyond planes changed a plane")

endmodule
